>>> hdl/mgf_pkg.sv
// Shared types and constants for the four-lane MGF1 SHA-512 mask generator.
// Holds the SHA-512 round constants, the initial hash value and the sequencer types.
// No dependencies.
package mgf_pkg;

	localparam int NUM_LANES    = 4;
	localparam int DIGEST_BYTES = 64;
	localparam int ROUNDS       = 80;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_LOAD    = 7'b0000010,
		ST_ROUND   = 7'b0000100,
		ST_FOLD    = 7'b0001000,
		ST_WRITE   = 7'b0010000,
		ST_READ    = 7'b0100000,
		ST_DELIVER = 7'b1000000
	} state_t;

	typedef enum logic {
		KIND_SEED    = 1'b0,
		KIND_REQUEST = 1'b1
	} kind_t;

	typedef struct packed {
		logic       init;
		logic       load_en;
		logic [7:0] load_byte;
		logic       round_en;
		logic [6:0] round_idx;
		logic       fold;
	} sha_ctrl_t;

	typedef logic [7:0][63:0] hash_words_t;

	localparam hash_words_t START_H = {
		64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
		64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
	};

	function automatic logic [63:0] round_k(input logic [6:0] idx);
		logic [63:0] k;
		case (idx)
			7'd0:  k = 64'h428a2f98d728ae22;
			7'd1:  k = 64'h7137449123ef65cd;
			7'd2:  k = 64'hb5c0fbcfec4d3b2f;
			7'd3:  k = 64'he9b5dba58189dbbc;
			7'd4:  k = 64'h3956c25bf348b538;
			7'd5:  k = 64'h59f111f1b605d019;
			7'd6:  k = 64'h923f82a4af194f9b;
			7'd7:  k = 64'hab1c5ed5da6d8118;
			7'd8:  k = 64'hd807aa98a3030242;
			7'd9:  k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c;
			7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f;
			7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235;
			7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2;
			7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5;
			7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275;
			7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4;
			7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab;
			7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f;
			7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2;
			7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f;
			7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc;
			7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed;
			7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de;
			7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6;
			7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364;
			7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791;
			7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218;
			7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a;
			7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8;
			7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99;
			7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63;
			7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373;
			7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc;
			7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72;
			7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28;
			7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915;
			7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c;
			7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e;
			7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba;
			7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae;
			7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84;
			7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc;
			7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6;
			7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec;
			7'd79: k = 64'h6c44198c4a475817;
			default: k = 64'h0;
		endcase
		return k;
	endfunction

endpackage

>>> hdl/mgf_ram.sv
// Generic single-port RAM with registered read data.
// Width and depth are parameters; no package dependency.
module mgf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

>>> hdl/mgf_sha_core.sv
// Iterative SHA-512 datapath: one round per cycle over a 16-word schedule shift line.
// Depends on mgf_pkg for the round constants, the initial hash value and the control struct.
module mgf_sha_core (
	input  logic                clk,
	input  mgf_pkg::sha_ctrl_t  ctrl,
	output mgf_pkg::hash_words_t h_words
);
	import mgf_pkg::*;

	logic [15:0][63:0] w_q;
	hash_words_t       v_q;
	hash_words_t       h_q;
	hash_words_t       sum;
	logic [63:0]       s0_w, s1_w, w_new;
	logic [63:0]       big_s0, big_s1, ch, maj, t1, t2;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	always_comb begin
		s0_w   = rotr(w_q[14], 1) ^ rotr(w_q[14], 8) ^ (w_q[14] >> 7);
		s1_w   = rotr(w_q[1], 19) ^ rotr(w_q[1], 61) ^ (w_q[1] >> 6);
		w_new  = w_q[15] + s0_w + w_q[6] + s1_w;
		big_s1 = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
		ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1     = v_q[7] + big_s1 + ch + round_k(ctrl.round_idx) + w_q[15];
		big_s0 = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
		maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2     = big_s0 + maj;
		for (int i = 0; i < 8; i++) begin
			sum[i] = h_q[i] + v_q[i];
		end
	end

	// The message block streams in a byte at a time; the first word ends up in w_q[15].
	always_ff @(posedge clk) begin
		if (ctrl.load_en) begin
			w_q <= {w_q[15][55:0], w_q[14:0], ctrl.load_byte};
		end else if (ctrl.round_en) begin
			w_q <= {w_q[14:0], w_new};
		end
		if (ctrl.init) begin
			h_q <= START_H;
			v_q <= START_H;
		end else if (ctrl.fold) begin
			h_q <= sum;
			v_q <= sum;
		end else if (ctrl.round_en) begin
			v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
	end

	assign h_words = h_q;

endmodule

>>> hdl/mgf1_sha512_4lane_generator.sv
// Four-lane MGF1 SHA-512 mask generator: a lane-partitioned seed RAM and per-lane digest RAMs.
// A request served from the buffer passes through the read and deliver states before its
// result is valid; the input stalls until then.
// A refill runs lanes one after another: per lane, one or two blocks of load, rounds and fold,
// then a write of the 64 digest bytes; one round unit is shared by all lanes.
// Reset (arst_n low) empties the buffer, clears the block counter and sets seed_length to 32.
// Depends on mgf_pkg, mgf_ram and mgf_sha_core.
module mgf1_sha512_4lane_generator #(
	parameter int SEED_STORE_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [1:0] lane,
	input  logic [6:0] byte_position,
	input  logic [7:0] seed_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] lane0_byte,
	output logic [7:0] lane1_byte,
	output logic [7:0] lane2_byte,
	output logic [7:0] lane3_byte
);
	import mgf_pkg::*;

	localparam int          AW       = $clog2(NUM_LANES * SEED_STORE_BYTES);
	localparam logic [10:0] MAX_SEED = 11'(SEED_STORE_BYTES - 4);

	state_t      state_q;
	logic [7:0]  cnt_q;
	logic [1:0]  lane_q;
	logic        blk_q;
	logic [6:0]  buf_pos_q;
	logic [31:0] ctr_q;
	logic [6:0]  seed_len_q;
	logic [6:0]  slen_q;
	logic        out_valid_q;
	logic        ld_valid_s1;
	logic [7:0]  g_s1;
	logic [7:0]  out_q [NUM_LANES];

	logic        in_xfer, seed_xfer, req_xfer, buf_empty;
	logic        deliver_go;
	logic [6:0]  slen_sat;
	logic [7:0]  msg_len;
	logic        two_blk;
	logic [7:0]  last_g;
	logic [10:0] bit_len;
	logic [7:0]  ctr_off;
	logic [7:0]  msg_byte;
	logic [AW-1:0] seed_addr;
	logic        seed_we;
	logic [7:0]  seed_rdata;
	logic [7:0]  dig_rdata [NUM_LANES];
	logic [5:0]  dig_addr;
	sha_ctrl_t   ctrl;
	hash_words_t h_words;
	logic        write_last;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign seed_xfer  = in_xfer && (kind == KIND_SEED);
	assign req_xfer   = in_xfer && (kind == KIND_REQUEST);
	assign buf_empty  = buf_pos_q[6];
	assign deliver_go = (state_q == ST_DELIVER) && (!out_valid_q || !out_stall);

	always_comb begin
		slen_sat = (MAX_SEED < {4'b0, seed_len_q}) ? MAX_SEED[6:0] : seed_len_q;
		msg_len  = {1'b0, slen_q} + 8'd4;
		two_blk  = msg_len > 8'd111;
		last_g   = two_blk ? 8'd255 : 8'd127;
		bit_len  = {msg_len, 3'b000};
		ctr_off  = g_s1 - {1'b0, slen_q};
		if (g_s1 < {1'b0, slen_q}) begin
			msg_byte = seed_rdata;
		end else if (g_s1 < msg_len) begin
			case (ctr_off[1:0])
				2'd0:    msg_byte = ctr_q[31:24];
				2'd1:    msg_byte = ctr_q[23:16];
				2'd2:    msg_byte = ctr_q[15:8];
				default: msg_byte = ctr_q[7:0];
			endcase
		end else if (g_s1 == msg_len) begin
			msg_byte = 8'h80;
		end else if (g_s1 == last_g) begin
			msg_byte = bit_len[7:0];
		end else if (g_s1 == last_g - 8'd1) begin
			msg_byte = {5'b0, bit_len[10:8]};
		end else begin
			msg_byte = 8'h00;
		end
	end

	// Seed RAM: written from the input port while idle, read while loading a block.
	always_comb begin
		if (state_q == ST_LOAD) begin
			seed_addr = AW'(lane_q) * AW'(SEED_STORE_BYTES) + AW'({blk_q, cnt_q[6:0]});
		end else begin
			seed_addr = AW'(lane) * AW'(SEED_STORE_BYTES) + AW'(byte_position);
		end
		seed_we = seed_xfer && ({4'b0, byte_position} < MAX_SEED);
	end

	mgf_ram #(
		.WIDTH(8),
		.DEPTH(NUM_LANES * SEED_STORE_BYTES)
	) u_seed_ram (
		.clk  (clk),
		.we   (seed_we),
		.re   (state_q == ST_LOAD),
		.addr (seed_addr),
		.wdata(seed_byte),
		.rdata(seed_rdata)
	);

	assign write_last = (state_q == ST_WRITE) && (cnt_q[5:0] == 6'd63);
	assign dig_addr   = (state_q == ST_WRITE) ? cnt_q[5:0] : buf_pos_q[5:0];

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_dig
		mgf_ram #(
			.WIDTH(8),
			.DEPTH(DIGEST_BYTES)
		) u_dig_ram (
			.clk  (clk),
			.we   ((state_q == ST_WRITE) && (lane_q == 2'(i))),
			.re   (state_q == ST_READ),
			.addr (dig_addr),
			.wdata(h_words[cnt_q[5:3]][8*(7 - cnt_q[2:0]) +: 8]),
			.rdata(dig_rdata[i])
		);
	end

	always_comb begin
		ctrl.init      = (req_xfer && buf_empty) || (write_last && (lane_q != 2'd3));
		ctrl.load_en   = ld_valid_s1;
		ctrl.load_byte = msg_byte;
		ctrl.round_en  = (state_q == ST_ROUND);
		ctrl.round_idx = cnt_q[6:0];
		ctrl.fold      = (state_q == ST_FOLD);
	end

	mgf_sha_core u_core (
		.clk    (clk),
		.ctrl   (ctrl),
		.h_words(h_words)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lane_q      <= '0;
			blk_q       <= 1'b0;
			buf_pos_q   <= 7'(DIGEST_BYTES);
			ctr_q       <= '0;
			seed_len_q  <= 7'd32;
			slen_q      <= '0;
			out_valid_q <= 1'b0;
			ld_valid_s1 <= 1'b0;
			g_s1        <= '0;
		end else begin
			ld_valid_s1 <= (state_q == ST_LOAD) && !cnt_q[7];
			g_s1        <= {blk_q, cnt_q[6:0]};
			if (cfg_write) begin
				seed_len_q <= cfg_data;
			end
			if (deliver_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (seed_xfer) begin
						ctr_q     <= '0;
						buf_pos_q <= 7'(DIGEST_BYTES);
					end else if (req_xfer) begin
						if (buf_empty) begin
							slen_q  <= slen_sat;
							lane_q  <= '0;
							blk_q   <= 1'b0;
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_LOAD: begin
					if (cnt_q[7]) begin
						cnt_q   <= '0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				ST_ROUND: begin
					if (cnt_q == 8'(ROUNDS - 1)) begin
						state_q <= ST_FOLD;
					end
					cnt_q <= cnt_q + 8'd1;
				end
				ST_FOLD: begin
					cnt_q <= '0;
					if (!blk_q && two_blk) begin
						blk_q   <= 1'b1;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (write_last) begin
						cnt_q <= '0;
						blk_q <= 1'b0;
						if (lane_q == 2'd3) begin
							ctr_q     <= ctr_q + 32'd1;
							buf_pos_q <= '0;
							state_q   <= ST_READ;
						end else begin
							lane_q  <= lane_q + 2'd1;
							state_q <= ST_LOAD;
						end
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				ST_READ: begin
					buf_pos_q <= buf_pos_q + 7'd1;
					state_q   <= ST_DELIVER;
				end
				ST_DELIVER: begin
					if (deliver_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (deliver_go) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				out_q[i] <= dig_rdata[i];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign lane0_byte = out_q[0];
	assign lane1_byte = out_q[1];
	assign lane2_byte = out_q[2];
	assign lane3_byte = out_q[3];

`ifndef ASSERT_OFF
	a_buf_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		buf_pos_q <= 7'(DIGEST_BYTES))
		else $error("buffer position beyond the digest");

	a_seed_restart: assert property (@(posedge clk) disable iff (!arst_n)
		seed_xfer |=> (ctr_q == 32'd0) && buf_empty)
		else $error("seed transfer did not restart the mask stream");

	a_read_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !buf_empty)
		else $error("digest read from an empty buffer");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (cnt_q < 8'(ROUNDS)))
		else $error("round counter overran");
`endif

endmodule
